### rtl/core/fcs_pkg.sv
package fcs_pkg;

  localparam int unsigned MAX_DISTINCT_DEF = 64;
  localparam int unsigned MAX_ITEMS_DEF    = 1024;
  localparam int unsigned VALUE_W          = 32;
  localparam int unsigned OCC_W            = 11;

  // source of the table read address
  typedef enum logic [1:0] {
    RD_J,
    RD_K,
    RD_ORD
  } rd_src_e;

  typedef struct packed {
    logic    load_item;   // capture input item, restart search
    logic    rd_en;       // read value/count table
    rd_src_e rd_src;
    logic    scan_issue;  // inner index advances, pending index follows
    logic    bump;        // matched entry: increment count or flag overflow
    logic    insert;      // no match: append entry or flag overflow
    logic    k_clear;
    logic    k_inc;
    logic    rk_hold;     // latch reference count, restart inner pass
    logic    rk_cmp;      // rank accumulate on pending entry
    logic    rk_write;    // order[rank] = k
    logic    ord_rd;
    logic    out_load;
    logic    run_clear;   // empty table, clear overflow
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic j_lt_total;
    logic k_last;
    logic out_free;
    logic last_item;
    logic total_zero;
  } sts_t;

endpackage

### rtl/core/frequency_counting_sort.sv
// Counts signed 32-bit values and, after the item flagged last_in, emits one
// result per distinct value in ascending order of occurrence count; values
// with equal counts come out in order of first appearance. Each result
// carries the value, its count, last_out on the final result of the run and
// overflow if during the run a new value met a full table (value dropped) or
// a count was already at MAX_ITEMS (count held). An item is taken only while
// the block is idle; each item is followed by a serial search of the table,
// one entry per cycle through a single registered read port. At the end of a
// run the stable ranking walks the table once per entry on the same port, and
// emission then reads the order table, then the value/count table, then loads
// the output register for each result, waiting while out_stall_i holds the
// output register. The final result may still wait in the output register
// while the next run's items are accepted.
module frequency_counting_sort #(
  parameter int unsigned MAX_DISTINCT = fcs_pkg::MAX_DISTINCT_DEF,
  parameter int unsigned MAX_ITEMS    = fcs_pkg::MAX_ITEMS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [fcs_pkg::VALUE_W-1:0] value_i,
  input  logic                               last_in_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [fcs_pkg::VALUE_W-1:0] out_value_o,
  output logic        [fcs_pkg::OCC_W-1:0]   occurrences_o,
  output logic                               last_out_o,
  output logic                               overflow_o
);
  import fcs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: search, rank and emit phases
  fcs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // table memories, counters, rank logic and output register
  fcs_datapath #(
    .MAX_DISTINCT (MAX_DISTINCT),
    .MAX_ITEMS    (MAX_ITEMS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .value_i       (value_i),
    .last_in_i     (last_in_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .out_value_o   (out_value_o),
    .occurrences_o (occurrences_o),
    .last_out_o    (last_out_o),
    .overflow_o    (overflow_o)
  );

  // an accepted item always keeps the input side busy for the search
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken on two consecutive cycles");

  // loading the final result of a run leaves the table empty
  a_run_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load && sts.k_last |=> sts.total_zero)
    else $error("table not emptied after last result");

  // the output register is only reloaded once its item has gone
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !out_valid_o || !out_stall_i)
    else $error("pending result overwritten");

  // a match and an append never happen together
  a_one_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.bump && cmd.insert))
    else $error("count bump and insert in one cycle");

endmodule

### rtl/core/fcs_datapath.sv
module fcs_datapath #(
  parameter int unsigned MAX_DISTINCT = fcs_pkg::MAX_DISTINCT_DEF,
  parameter int unsigned MAX_ITEMS    = fcs_pkg::MAX_ITEMS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fcs_pkg::cmd_t                       cmd_i,
  output fcs_pkg::sts_t                       sts_o,
  input  logic signed [fcs_pkg::VALUE_W-1:0]  value_i,
  input  logic                                last_in_i,
  input  logic                                out_stall_i,
  output logic                                out_valid_o,
  output logic signed [fcs_pkg::VALUE_W-1:0]  out_value_o,
  output logic        [fcs_pkg::OCC_W-1:0]    occurrences_o,
  output logic                                last_out_o,
  output logic                                overflow_o
);
  import fcs_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_DISTINCT);
  localparam int unsigned TOT_W = $clog2(MAX_DISTINCT + 1);
  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);

  logic [VALUE_W-1:0] vals_mem [MAX_DISTINCT];
  logic [CNT_W-1:0]   cnt_mem  [MAX_DISTINCT];
  logic [IDX_W-1:0]   ord_mem  [MAX_DISTINCT];

  logic [VALUE_W-1:0] item_q, rv_q;
  logic [CNT_W-1:0]   rc_q, ck_q;
  logic               last_item_q;
  logic [TOT_W-1:0]   total_q, j_q, k_q;
  logic [IDX_W-1:0]   p_q, rank_q, ord_q;
  logic               ovf_q;

  logic               out_valid_q, out_last_q, out_ovf_q;
  logic [VALUE_W-1:0] out_value_q;
  logic [OCC_W-1:0]   out_occ_q;

  logic [IDX_W-1:0]   rd_addr;
  logic               cnt_full, tbl_full, lesser;
  logic               cnt_we;
  logic [IDX_W-1:0]   cnt_wa;
  logic [CNT_W-1:0]   cnt_wd;

  assign cnt_full = (rc_q >= CNT_W'(MAX_ITEMS));
  assign tbl_full = (total_q == TOT_W'(MAX_DISTINCT));
  // stable order: smaller count first, earlier entry first on a tie
  assign lesser   = (rc_q < ck_q) || ((rc_q == ck_q) && (TOT_W'(p_q) < k_q));

  always_comb begin
    case (cmd_i.rd_src)
      RD_J:    rd_addr = j_q[IDX_W-1:0];
      RD_K:    rd_addr = k_q[IDX_W-1:0];
      RD_ORD:  rd_addr = ord_q;
      default: rd_addr = j_q[IDX_W-1:0];
    endcase
  end

  always_comb begin
    cnt_we = 1'b0;
    cnt_wa = p_q;
    cnt_wd = rc_q + CNT_W'(1);
    if (cmd_i.bump && !cnt_full) begin
      cnt_we = 1'b1;
    end else if (cmd_i.insert && !tbl_full) begin
      cnt_we = 1'b1;
      cnt_wa = total_q[IDX_W-1:0];
      cnt_wd = CNT_W'(1);
    end
  end

  // table memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rv_q <= vals_mem[rd_addr];
      rc_q <= cnt_mem[rd_addr];
    end
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    if (cmd_i.insert && !tbl_full) begin
      vals_mem[total_q[IDX_W-1:0]] <= item_q;
    end
    if (cmd_i.rk_write) begin
      ord_mem[rank_q] <= k_q[IDX_W-1:0];
    end
    if (cmd_i.ord_rd) begin
      ord_q <= ord_mem[k_q[IDX_W-1:0]];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q      <= value_i;
      last_item_q <= last_in_i;
    end
    if (cmd_i.scan_issue) begin
      p_q <= j_q[IDX_W-1:0];
    end
    if (cmd_i.rk_hold) begin
      ck_q <= rc_q;
    end
    if (cmd_i.out_load) begin
      out_value_q <= rv_q;
      out_occ_q   <= OCC_W'(rc_q);
      out_last_q  <= sts_o.k_last;
      out_ovf_q   <= ovf_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      j_q         <= '0;
      k_q         <= '0;
      rank_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load_item || cmd_i.rk_hold) begin
        j_q <= '0;
      end else if (cmd_i.scan_issue) begin
        j_q <= j_q + TOT_W'(1);
      end
      if (cmd_i.k_clear) begin
        k_q <= '0;
      end else if (cmd_i.k_inc) begin
        k_q <= k_q + TOT_W'(1);
      end
      if (cmd_i.rk_hold) begin
        rank_q <= '0;
      end else if (cmd_i.rk_cmp && lesser) begin
        rank_q <= rank_q + IDX_W'(1);
      end
      if (cmd_i.run_clear) begin
        total_q <= '0;
        ovf_q   <= 1'b0;
      end else begin
        if (cmd_i.insert && !tbl_full) begin
          total_q <= total_q + TOT_W'(1);
        end
        if ((cmd_i.insert && tbl_full) || (cmd_i.bump && cnt_full)) begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.hit        = (rv_q == item_q);
  assign sts_o.j_lt_total = (j_q < total_q);
  assign sts_o.k_last     = ((k_q + TOT_W'(1)) == total_q);
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;
  assign sts_o.last_item  = last_item_q;
  assign sts_o.total_zero = (total_q == '0);

  assign out_valid_o   = out_valid_q;
  assign out_value_o   = out_value_q;
  assign occurrences_o = out_occ_q;
  assign last_out_o    = out_last_q;
  assign overflow_o    = out_ovf_q;

endmodule

### rtl/core/fcs_ctrl.sv
module fcs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  fcs_pkg::sts_t sts_i,
  output fcs_pkg::cmd_t cmd_o
);
  import fcs_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_RK_LOAD = 3'd2;
  localparam logic [2:0] S_RK_HOLD = 3'd3;
  localparam logic [2:0] S_RK_SCAN = 3'd4;
  localparam logic [2:0] S_EM_ORD  = 3'd5;
  localparam logic [2:0] S_EM_DAT  = 3'd6;
  localparam logic [2:0] S_EM_OUT  = 3'd7;

  logic [2:0] state_q, state_d;
  logic       pend_q, pend_d;   // table read data is valid for compare

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    pend_d  = pend_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          pend_d          = 1'b0;
          state_d         = S_SCAN;
        end
      end
      S_SCAN: begin
        if (pend_q && sts_i.hit) begin
          cmd_o.bump = 1'b1;
          pend_d     = 1'b0;
        end else if (sts_i.j_lt_total) begin
          cmd_o.rd_en      = 1'b1;
          cmd_o.rd_src     = RD_J;
          cmd_o.scan_issue = 1'b1;
          pend_d           = 1'b1;
        end else begin
          cmd_o.insert = 1'b1;
          pend_d       = 1'b0;
        end
        if (cmd_o.bump || cmd_o.insert) begin
          if (sts_i.last_item) begin
            cmd_o.k_clear = 1'b1;
            state_d       = S_RK_LOAD;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_RK_LOAD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_src = RD_K;
        state_d      = S_RK_HOLD;
      end
      S_RK_HOLD: begin
        cmd_o.rk_hold = 1'b1;
        pend_d        = 1'b0;
        state_d       = S_RK_SCAN;
      end
      S_RK_SCAN: begin
        cmd_o.rk_cmp = pend_q;
        if (sts_i.j_lt_total) begin
          cmd_o.rd_en      = 1'b1;
          cmd_o.rd_src     = RD_J;
          cmd_o.scan_issue = 1'b1;
          pend_d           = 1'b1;
        end else if (pend_q) begin
          pend_d = 1'b0;
        end else begin
          cmd_o.rk_write = 1'b1;
          if (sts_i.k_last) begin
            cmd_o.k_clear = 1'b1;
            state_d       = S_EM_ORD;
          end else begin
            cmd_o.k_inc = 1'b1;
            state_d     = S_RK_LOAD;
          end
        end
      end
      S_EM_ORD: begin
        cmd_o.ord_rd = 1'b1;
        state_d      = S_EM_DAT;
      end
      S_EM_DAT: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_src = RD_ORD;
        state_d      = S_EM_OUT;
      end
      S_EM_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (sts_i.k_last) begin
            cmd_o.run_clear = 1'b1;
            state_d         = S_IDLE;
          end else begin
            cmd_o.k_inc = 1'b1;
            state_d     = S_EM_ORD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
        pend_d  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

endmodule
